// File: src/contact_debounce_edge_alarm_macros.svh
// Assertion macros shared by the contact debounce and alarm modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef CONTACT_DEBOUNCE_EDGE_ALARM_MACROS_SVH
`define CONTACT_DEBOUNCE_EDGE_ALARM_MACROS_SVH

// same-cycle implication
`define CDEA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDEA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cdea_pkg.sv
// Shared types and constants for the contact debounce and edge alarm block.
// No dependencies.
package cdea_pkg;

  localparam int DefChannels   = 6;
  localparam int DefCountWidth = 16;
  localparam int DefTimerWidth = 20;

  localparam int AgeWidth = 16;
  localparam logic [AgeWidth-1:0] AgeMax = '1;

  localparam int DefDebounce = 5;
  localparam int DefTrigMask = 61;
  localparam int DefHotMask  = 2;
  localparam int DefAlarm    = 3000;
  localparam int DefCooldown = 6000;

  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDebounce = 3'd0,
    CfgTrigMask = 3'd1,
    CfgHotMask  = 3'd2,
    CfgAlarm    = 3'd3,
    CfgCooldown = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic fired;
    logic relay;
    logic running;
    logic cooldown;
  } alarm_stat_t;

endpackage

// File: src/cdea_debounce.sv
// Per-channel debounce, accepted levels and wrapping rise/fall counters.
// Depends on cdea_pkg and the assertion macro header.
`include "contact_debounce_edge_alarm_macros.svh"

module cdea_debounce #(
  parameter int CHANNELS    = 6,
  parameter int COUNT_WIDTH = 16,
  parameter int SEL_WIDTH   = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_i,
  input  logic [CHANNELS-1:0]          raw_i,
  input  logic [SEL_WIDTH-1:0]         sel_i,
  input  logic [cdea_pkg::AgeWidth-1:0] debounce_i,
  output logic [CHANNELS-1:0]          levels_o,
  output logic [CHANNELS-1:0]          rise_o,
  output logic [CHANNELS-1:0]          fall_o,
  output logic [COUNT_WIDTH-1:0]       rise_cnt_o,
  output logic [COUNT_WIDTH-1:0]       fall_cnt_o
);
  import cdea_pkg::*;

  logic                   primed_q;
  logic [CHANNELS-1:0]    last_raw_q;
  logic [CHANNELS-1:0]    acc_q, acc_d;
  logic [AgeWidth-1:0]    age_q [CHANNELS];
  logic [AgeWidth-1:0]    age_d [CHANNELS];
  logic [COUNT_WIDTH-1:0] rise_cnt_q [CHANNELS];
  logic [COUNT_WIDTH-1:0] rise_cnt_d [CHANNELS];
  logic [COUNT_WIDTH-1:0] fall_cnt_q [CHANNELS];
  logic [COUNT_WIDTH-1:0] fall_cnt_d [CHANNELS];
  logic [CHANNELS-1:0]    take;

  always_comb begin
    rise_cnt_o = '0;
    fall_cnt_o = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!primed_q || raw_i[i] != last_raw_q[i]) begin
        age_d[i] = '0;
      end else if (age_q[i] != AgeMax) begin
        age_d[i] = age_q[i] + AgeWidth'(1);
      end else begin
        age_d[i] = age_q[i];
      end
      take[i]   = primed_q && (age_d[i] > debounce_i) && (raw_i[i] != acc_q[i]);
      acc_d[i]  = (take[i] || !primed_q) ? raw_i[i] : acc_q[i];
      rise_o[i] = take[i] && raw_i[i];
      fall_o[i] = take[i] && !raw_i[i];
      rise_cnt_d[i] = rise_cnt_q[i] + COUNT_WIDTH'(rise_o[i]);
      fall_cnt_d[i] = fall_cnt_q[i] + COUNT_WIDTH'(fall_o[i]);
      if (sel_i == SEL_WIDTH'(i)) begin
        rise_cnt_o = rise_cnt_d[i];
        fall_cnt_o = fall_cnt_d[i];
      end
    end
    levels_o = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q   <= 1'b0;
      last_raw_q <= '0;
      acc_q      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        age_q[i]      <= '0;
        rise_cnt_q[i] <= '0;
        fall_cnt_q[i] <= '0;
      end
    end else if (upd_i) begin
      primed_q   <= 1'b1;
      last_raw_q <= raw_i;
      acc_q      <= acc_d;
      for (int i = 0; i < CHANNELS; i++) begin
        age_q[i]      <= age_d[i];
        rise_cnt_q[i] <= rise_cnt_d[i];
        fall_cnt_q[i] <= fall_cnt_d[i];
      end
    end
  end

  `CDEA_ASSERT_NXT(a_primes, upd_i && !primed_q, primed_q, "first transfer did not prime")
  `CDEA_ASSERT_IMP(a_edge_excl, 1'b1, (rise_o & fall_o) == '0, "rise and fall on same channel")
  `CDEA_ASSERT_IMP(a_edge_stable, upd_i, ((rise_o | fall_o) & (raw_i ^ last_raw_q)) == '0,
                   "edge accepted on a changing raw level")

endmodule

// File: src/cdea_alarm.sv
// One-shot alarm timer, cooldown timer, relay and hot trigger qualification.
// Depends on cdea_pkg and the assertion macro header.
`include "contact_debounce_edge_alarm_macros.svh"

module cdea_alarm #(
  parameter int CHANNELS    = 6,
  parameter int TIMER_WIDTH = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        stop_i,
  input  logic [CHANNELS-1:0]         rise_i,
  input  logic [CHANNELS-1:0]         fall_i,
  input  logic [CHANNELS-1:0]         trig_mask_i,
  input  logic [CHANNELS-1:0]         hot_mask_i,
  input  logic [TIMER_WIDTH-1:0]      alarm_ticks_i,
  input  logic [TIMER_WIDTH-1:0]      cooldown_ticks_i,
  output logic [CHANNELS-1:0]         hot_o,
  output cdea_pkg::alarm_stat_t       stat_o
);
  import cdea_pkg::*;

  logic                   al_act_q, al_act_d;
  logic [TIMER_WIDTH-1:0] al_rem_q, al_rem_d;
  logic                   cd_act_q, cd_act_d;
  logic [TIMER_WIDTH-1:0] cd_rem_q, cd_rem_d;
  logic                   relay_q, relay_d;
  logic                   fired;
  logic [TIMER_WIDTH-1:0] al_len, cd_len;

  assign al_len = (alarm_ticks_i == '0) ? TIMER_WIDTH'(1) : alarm_ticks_i;
  assign cd_len = (cooldown_ticks_i == '0) ? TIMER_WIDTH'(1) : cooldown_ticks_i;

  always_comb begin
    al_act_d = al_act_q;
    al_rem_d = al_rem_q;
    cd_act_d = cd_act_q;
    cd_rem_d = cd_rem_q;
    relay_d  = relay_q;
    fired    = 1'b0;

    if (cd_act_q) begin
      cd_rem_d = cd_rem_q - TIMER_WIDTH'(1);
      cd_act_d = (cd_rem_d != '0);
    end
    if (al_act_q) begin
      al_rem_d = al_rem_q - TIMER_WIDTH'(1);
      if (al_rem_d == '0) begin
        al_act_d = 1'b0;
        relay_d  = 1'b1;
        fired    = 1'b1;
        if (!cd_act_d) begin
          cd_act_d = 1'b1;
          cd_rem_d = cd_len;
        end
      end
    end

    if (stop_i) begin
      al_act_d = 1'b0;
      al_rem_d = '0;
      relay_d  = 1'b0;
    end

    hot_o = ((rise_i & trig_mask_i) | (fall_i & ~trig_mask_i)) & hot_mask_i
            & {CHANNELS{!cd_act_d}};
    if (hot_o != '0 && !al_act_d) begin
      al_act_d = 1'b1;
      al_rem_d = al_len;
    end

    stat_o.fired    = fired;
    stat_o.relay    = relay_d;
    stat_o.running  = al_act_d;
    stat_o.cooldown = cd_act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_act_q <= 1'b0;
      al_rem_q <= '0;
      cd_act_q <= 1'b0;
      cd_rem_q <= '0;
      relay_q  <= 1'b0;
    end else if (upd_i) begin
      al_act_q <= al_act_d;
      al_rem_q <= al_rem_d;
      cd_act_q <= cd_act_d;
      cd_rem_q <= cd_rem_d;
      relay_q  <= relay_d;
    end
  end

  `CDEA_ASSERT_NXT(a_fire_cool, upd_i && fired, cd_act_q && !al_act_q,
                   "expiry did not leave cooldown running")
  `CDEA_ASSERT_NXT(a_hot_start, upd_i && (hot_o != '0), al_act_q,
                   "hot trigger did not leave timer running")
  `CDEA_ASSERT_NXT(a_stop_relay, upd_i && stop_i && (hot_o == '0), !relay_q && !al_act_q,
                   "stop did not clear relay and timer")

endmodule

// File: src/contact_debounce_edge_alarm.sv
// Top level of the contact debounce and edge alarm block: configuration,
// input stage, result stage. Depends on cdea_pkg, cdea_debounce, cdea_alarm.
//
// One item is taken per cycle while the output is not stalled: a transfer
// on the input channel lands in an input register, and from there its single
// result is computed and written to the output register. The rate is set by
// the update of the debounce ages, counters and timers, which is computed
// combinationally from the input register. A stall on the output holds both
// stages; the input stalls only when both are full.
module contact_debounce_edge_alarm #(
  parameter int CHANNELS    = cdea_pkg::DefChannels,
  parameter int COUNT_WIDTH = cdea_pkg::DefCountWidth,
  parameter int TIMER_WIDTH = cdea_pkg::DefTimerWidth,
  localparam int SelWidth   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int CfgWidth   = (TIMER_WIDTH > cdea_pkg::AgeWidth)
                              ? ((TIMER_WIDTH > CHANNELS) ? TIMER_WIDTH : CHANNELS)
                              : ((cdea_pkg::AgeWidth > CHANNELS) ? cdea_pkg::AgeWidth
                                                                 : CHANNELS)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdea_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]              cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [CHANNELS-1:0]              pin_levels_i,
  input  logic                             alarm_stop_i,
  input  logic [SelWidth-1:0]              read_channel_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [CHANNELS-1:0]              debounced_levels_o,
  output logic [CHANNELS-1:0]              rise_mask_o,
  output logic [CHANNELS-1:0]              fall_mask_o,
  output logic [CHANNELS-1:0]              hot_trigger_mask_o,
  output logic                             alarm_fired_o,
  output logic                             relay_on_o,
  output logic                             alarm_running_o,
  output logic                             cooldown_on_o,
  output logic [COUNT_WIDTH-1:0]           rise_count_o,
  output logic [COUNT_WIDTH-1:0]           fall_count_o
);
  import cdea_pkg::*;

  logic [AgeWidth-1:0]    debounce_q;
  logic [CHANNELS-1:0]    trig_mask_q, hot_mask_q;
  logic [TIMER_WIDTH-1:0] alarm_ticks_q, cooldown_ticks_q;

  logic                   in_valid_q;
  logic [CHANNELS-1:0]    pin_q;
  logic                   stop_q;
  logic [SelWidth-1:0]    sel_q;

  logic                   out_valid_q;
  logic                   out_free, upd;

  logic [CHANNELS-1:0]    levels, rises, falls, hots;
  logic [COUNT_WIDTH-1:0] rise_cnt, fall_cnt;
  alarm_stat_t            stat;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q       <= AgeWidth'(DefDebounce);
      trig_mask_q      <= CHANNELS'(DefTrigMask);
      hot_mask_q       <= CHANNELS'(DefHotMask);
      alarm_ticks_q    <= TIMER_WIDTH'(DefAlarm);
      cooldown_ticks_q <= TIMER_WIDTH'(DefCooldown);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgDebounce: debounce_q       <= cfg_data_i[AgeWidth-1:0];
        CfgTrigMask: trig_mask_q      <= cfg_data_i[CHANNELS-1:0];
        CfgHotMask:  hot_mask_q       <= cfg_data_i[CHANNELS-1:0];
        CfgAlarm:    alarm_ticks_q    <= cfg_data_i[TIMER_WIDTH-1:0];
        CfgCooldown: cooldown_ticks_q <= cfg_data_i[TIMER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pin_q  <= pin_levels_i;
      stop_q <= alarm_stop_i;
      sel_q  <= read_channel_i;
    end
  end

  cdea_debounce #(
    .CHANNELS    (CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .SEL_WIDTH   (SelWidth)
  ) u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .raw_i      (pin_q),
    .sel_i      (sel_q),
    .debounce_i (debounce_q),
    .levels_o   (levels),
    .rise_o     (rises),
    .fall_o     (falls),
    .rise_cnt_o (rise_cnt),
    .fall_cnt_o (fall_cnt)
  );

  cdea_alarm #(
    .CHANNELS    (CHANNELS),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_alarm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (upd),
    .stop_i           (stop_q),
    .rise_i           (rises),
    .fall_i           (falls),
    .trig_mask_i      (trig_mask_q),
    .hot_mask_i       (hot_mask_q),
    .alarm_ticks_i    (alarm_ticks_q),
    .cooldown_ticks_i (cooldown_ticks_q),
    .hot_o            (hots),
    .stat_o           (stat)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      debounced_levels_o <= levels;
      rise_mask_o        <= rises;
      fall_mask_o        <= falls;
      hot_trigger_mask_o <= hots;
      alarm_fired_o      <= stat.fired;
      relay_on_o         <= stat.relay;
      alarm_running_o    <= stat.running;
      cooldown_on_o      <= stat.cooldown;
      rise_count_o       <= rise_cnt;
      fall_count_o       <= fall_cnt;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
